// File: hw/rtl/plls_pkg.sv
// ----------------------------------------------------------------------------
// plls_pkg : shared types and constants for the latency statistics block
// Sequencer states, default sizes and fixed field widths.
// ----------------------------------------------------------------------------
package plls_pkg;

  localparam int unsigned LinesDef    = 16;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned LineW       = 4;
  localparam int unsigned LatW        = 16;
  localparam int unsigned CntW        = 32;

  localparam logic KindSample = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SLOAD,
    ST_SDIV,
    ST_SWR,
    ST_RRD,
    ST_RCHK,
    ST_SUMDIV,
    ST_SUMOUT
  } plls_state_e;

endpackage

// File: hw/rtl/plls_req_if.sv
// ----------------------------------------------------------------------------
// plls_req_if : input channel of the latency statistics block
// Carries one sample or report request word.
// ----------------------------------------------------------------------------
interface plls_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  line_index;
  logic [15:0] latency;

  modport source (output valid, kind, line_index, latency, input ready);
  modport sink   (input valid, kind, line_index, latency, output ready);
endinterface

// File: hw/rtl/plls_rsp_if.sv
// ----------------------------------------------------------------------------
// plls_rsp_if : result channel of the latency statistics block
// Carries one per-line or summary result word.
// ----------------------------------------------------------------------------
interface plls_rsp_if #(
  parameter int unsigned MEAN_W = 24
);
  logic              valid;
  logic              ready;
  logic              is_summary;
  logic [3:0]        line_number;
  logic [31:0]       event_count;
  logic [MEAN_W-1:0] mean_latency;
  logic [15:0]       peak_latency;
  logic              no_data;
  logic              last_result;

  modport source (output valid, is_summary, line_number, event_count, mean_latency,
                  peak_latency, no_data, last_result, input ready);
  modport sink   (input valid, is_summary, line_number, event_count, mean_latency,
                  peak_latency, no_data, last_result, output ready);
endinterface

// File: hw/rtl/per_line_latency_statistics.sv
// ----------------------------------------------------------------------------
// per_line_latency_statistics : per-line interrupt latency statistics
// Saturating count, cumulative moving average and maximum per line.
// ----------------------------------------------------------------------------
// A sample word (kind 0) updates one line's count, truncated moving average
// (16.FRAC_BITS fixed point) and peak, and produces nothing; a line index not
// below LINES is dropped. A report word (kind 1) produces one word per line
// with a nonzero count, in rising line order, then a summary word flagged
// last. A sample reads the line's stores, loads the working registers,
// then works out the average step in the one-bit-per-cycle restoring
// divider (DW = 16 + FRAC_BITS + clog2(LINES+1) = 29 bits at the defaults)
// and writes the line back. A first sample of a line skips the divider.
// A report reads and checks each line in turn, stalling on the result
// side for each line word it emits, then works out the summary mean in
// the same divider (skipped when no line has a nonzero average). The
// block takes no new word while a sample or report is in progress. The three
// per-line stores are single-port memories with registered read; a bit per
// line marks it as written, so reset needs no clearing pass.
module per_line_latency_statistics #(
  parameter int unsigned LINES     = plls_pkg::LinesDef,
  parameter int unsigned FRAC_BITS = plls_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  plls_req_if.sink             req_i,
  plls_rsp_if.source           rsp_o
);
  import plls_pkg::*;

  localparam int unsigned AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned MW = LatW + FRAC_BITS;          // mean width
  localparam int unsigned NW = $clog2(LINES + 1);         // nonzero-mean count
  localparam int unsigned SW = MW + NW;                   // mean sum width
  localparam int unsigned DW = SW;                        // dividend width
  localparam int unsigned PW = $clog2(DW + 1);
  localparam logic [PW-1:0] StepLast = PW'(DW - 1);
  localparam logic [AW-1:0] IdxLast  = AW'(LINES - 1);
  localparam logic [CntW-1:0] CntMax = '1;

  // per-line stores
  logic [CntW-1:0] cnt_mem  [LINES];
  logic [MW-1:0]   mean_mem [LINES];
  logic [LatW-1:0] peak_mem [LINES];
  logic [LINES-1:0] vld_q, vld_d;

  plls_state_e state_q, state_d;

  logic [AW-1:0]   addr_q, addr_d;
  logic [CntW-1:0] rd_cnt_q;
  logic [MW-1:0]   rd_mean_q;
  logic [LatW-1:0] rd_peak_q;
  logic            rd_vld_q;
  logic [CntW-1:0] cur_cnt;
  logic [MW-1:0]   cur_mean;
  logic [LatW-1:0] cur_peak;

  // sample working registers
  logic [LatW-1:0] lat_q, lat_d;
  logic [CntW-1:0] nc_q, nc_d;
  logic [MW-1:0]   nm_q, nm_d;
  logic [LatW-1:0] np_q, np_d;
  logic            first_q, first_d;
  logic            up_q, up_d;
  logic [MW-1:0]   lfx;
  logic [MW-1:0]   wr_mean;
  logic            wr_en;

  // shared divider
  logic [DW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic [PW-1:0]   step_q, step_d;
  logic [CntW:0]   sh, sub;
  logic            ge;

  // report accumulators
  logic [CntW-1:0] tot_q, tot_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [NW-1:0]   nz_q, nz_d;
  logic [LatW-1:0] pk_q, pk_d;
  logic [CntW:0]   tot_add;

  // result register
  logic            ov_q, ov_d;
  logic            o_sum_q, o_sum_d;
  logic [3:0]      o_line_q, o_line_d;
  logic [CntW-1:0] o_cnt_q, o_cnt_d;
  logic [MW-1:0]   o_mean_q, o_mean_d;
  logic [LatW-1:0] o_peak_q, o_peak_d;
  logic            o_nd_q, o_nd_d;
  logic            out_free;
  logic            rchk_go;
  logic            in_acc;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || rsp_o.ready;

  assign cur_cnt  = rd_vld_q ? rd_cnt_q  : '0;
  assign cur_mean = rd_vld_q ? rd_mean_q : '0;
  assign cur_peak = rd_vld_q ? rd_peak_q : '0;
  assign lfx      = MW'(lat_q) << FRAC_BITS;
  assign rchk_go  = (cur_cnt == '0) || out_free;

  assign sh  = {rem_q, quo_q[DW-1]};
  assign ge  = (sh >= {1'b0, dvs_q});
  assign sub = sh - {1'b0, dvs_q};

  assign tot_add = {1'b0, tot_q} + {1'b0, cur_cnt};

  always_comb begin
    if (first_q) begin
      wr_mean = nm_q;
    end else if (up_q) begin
      wr_mean = nm_q + MW'(quo_q);
    end else begin
      wr_mean = nm_q - MW'(quo_q) - MW'(rem_q != '0);
    end
  end
  assign wr_en = (state_q == ST_SWR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_i.kind == KindReport) begin
            state_d = ST_RRD;
          end else if (32'(req_i.line_index) < LINES) begin
            state_d = ST_SRD;
          end
        end
      end
      ST_SRD:   state_d = ST_SLOAD;
      ST_SLOAD: state_d = (cur_cnt == '0) ? ST_SWR : ST_SDIV;
      ST_SDIV:  if (step_q == StepLast) state_d = ST_SWR;
      ST_SWR:   state_d = ST_IDLE;
      ST_RRD:   state_d = ST_RCHK;
      ST_RCHK: begin
        if (rchk_go) begin
          if (addr_q != IdxLast) begin
            state_d = ST_RRD;
          end else if (nz_d == '0) begin
            state_d = ST_SUMOUT;
          end else begin
            state_d = ST_SUMDIV;
          end
        end
      end
      ST_SUMDIV: if (step_q == StepLast) state_d = ST_SUMOUT;
      ST_SUMOUT: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    addr_d = addr_q; lat_d = lat_q; nc_d = nc_q; nm_d = nm_q; np_d = np_q;
    first_d = first_q; up_d = up_q;
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; step_d = step_q;
    tot_d = tot_q; sum_d = sum_q; nz_d = nz_q; pk_d = pk_q;
    vld_d = vld_q;
    ov_d = ov_q && !rsp_o.ready;
    o_sum_d = o_sum_q; o_line_d = o_line_q; o_cnt_d = o_cnt_q;
    o_mean_d = o_mean_q; o_peak_d = o_peak_q; o_nd_d = o_nd_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          addr_d = (req_i.kind == KindReport) ? '0 : AW'(req_i.line_index);
          lat_d  = req_i.latency;
          tot_d  = '0; sum_d = '0; nz_d = '0; pk_d = '0;
        end
      end
      ST_SLOAD: begin
        np_d   = (lat_q > cur_peak) ? lat_q : cur_peak;
        step_d = '0;
        rem_d  = '0;
        if (cur_cnt == '0) begin
          first_d = 1'b1;
          nc_d    = CntW'(1);
          nm_d    = lfx;
        end else begin
          first_d = 1'b0;
          nc_d    = (cur_cnt == CntMax) ? cur_cnt : cur_cnt + CntW'(1);
          dvs_d   = (cur_cnt == CntMax) ? cur_cnt : cur_cnt + CntW'(1);
          nm_d    = cur_mean;
          up_d    = (lfx >= cur_mean);
          quo_d   = (lfx >= cur_mean) ? DW'(lfx - cur_mean) : DW'(cur_mean - lfx);
        end
      end
      ST_SDIV, ST_SUMDIV: begin
        rem_d  = ge ? sub[CntW-1:0] : sh[CntW-1:0];
        quo_d  = {quo_q[DW-2:0], ge};
        step_d = step_q + PW'(1);
      end
      ST_SWR: begin
        vld_d[addr_q] = 1'b1;
      end
      ST_RCHK: begin
        if (rchk_go) begin
          tot_d = tot_add[CntW] ? CntMax : tot_add[CntW-1:0];
          if (cur_mean != '0) begin
            sum_d = sum_q + SW'(cur_mean);
            nz_d  = nz_q + NW'(1);
          end
          pk_d = (cur_peak > pk_q) ? cur_peak : pk_q;
          if (cur_cnt != '0) begin
            ov_d     = 1'b1;
            o_sum_d  = 1'b0;
            o_line_d = 4'(addr_q);
            o_cnt_d  = cur_cnt;
            o_mean_d = cur_mean;
            o_peak_d = cur_peak;
            o_nd_d   = 1'b0;
          end
          addr_d = addr_q + AW'(1);
          // set up the summary division
          quo_d  = DW'(sum_d);
          dvs_d  = CntW'(nz_d);
          rem_d  = '0;
          step_d = '0;
        end
      end
      ST_SUMOUT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_sum_d  = 1'b1;
          o_line_d = '0;
          o_cnt_d  = tot_q;
          o_mean_d = (nz_q == '0) ? '0 : MW'(quo_q);
          o_peak_d = pk_q;
          o_nd_d   = (nz_q == '0);
        end
      end
      default: ;
    endcase
  end

  // stores: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[addr_q]  <= nc_q;
      mean_mem[addr_q] <= wr_mean;
      peak_mem[addr_q] <= np_q;
    end
    rd_cnt_q  <= cnt_mem[addr_q];
    rd_mean_q <= mean_mem[addr_q];
    rd_peak_q <= peak_mem[addr_q];
    rd_vld_q  <= vld_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; lat_q <= lat_d; nc_q <= nc_d; nm_q <= nm_d; np_q <= np_d;
    first_q <= first_d; up_q <= up_d;
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; step_q <= step_d;
    tot_q <= tot_d; sum_q <= sum_d; nz_q <= nz_d; pk_q <= pk_d;
    o_sum_q <= o_sum_d; o_line_q <= o_line_d; o_cnt_q <= o_cnt_d;
    o_mean_q <= o_mean_d; o_peak_q <= o_peak_d; o_nd_q <= o_nd_d;
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.is_summary   = o_sum_q;
  assign rsp_o.line_number  = o_line_q;
  assign rsp_o.event_count  = o_cnt_q;
  assign rsp_o.mean_latency = o_mean_q;
  assign rsp_o.peak_latency = o_peak_q;
  assign rsp_o.no_data      = o_nd_q;
  assign rsp_o.last_result  = o_sum_q;

endmodule
